>>> src/s2e_pkg.sv
// ----------------------------------------------------------------------------
// s2e_pkg
// Shared widths and payload types for the symmetric 2x2 eigenvalue unit.
// ----------------------------------------------------------------------------
package s2e_pkg;

	// input entries, signed Q15.16
	localparam int EntryW = 32;
	// sum and difference of two entries
	localparam int SumW   = EntryW + 1;
	// products of two magnitudes
	localparam int ProdW  = 2 * EntryW;
	// discriminant (xx-yy)^2 + 4*xy^2
	localparam int RadW   = ProdW + 2;
	// floor(sqrt(discriminant))
	localparam int RootW  = RadW / 2;
	// square root remainder, one spare bit
	localparam int RemW   = RadW + 1;
	// eigenvalue outputs
	localparam int EigW   = SumW + 1;
	// sqrt stages, one result bit each
	localparam int SqrtStages = RootW;

	// request leaving the front end: discriminant, trace, last mark
	typedef struct packed {
		logic [RadW-1:0]        rad;
		logic signed [SumW-1:0] sum;
		logic                   last;
	} front_t;

	// request inside the square root pipeline
	typedef struct packed {
		logic [RemW-1:0]        rem;
		logic [RootW-1:0]       root;
		logic signed [SumW-1:0] sum;
		logic                   last;
	} sqrt_t;

endpackage

>>> src/s2e_if.sv
// ----------------------------------------------------------------------------
// s2e_in_if / s2e_out_if
// Valid/ready channels for matrix requests and eigenvalue results.
// ----------------------------------------------------------------------------
interface s2e_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [s2e_pkg::EntryW-1:0]    entry_xx;
	logic signed [s2e_pkg::EntryW-1:0]    entry_xy;
	logic signed [s2e_pkg::EntryW-1:0]    entry_yy;
	logic                                 last_in;

	modport source (output valid, entry_xx, entry_xy, entry_yy, last_in, input ready);
	modport sink   (input valid, entry_xx, entry_xy, entry_yy, last_in, output ready);
endinterface

interface s2e_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [s2e_pkg::EigW-1:0]      eig_large;
	logic signed [s2e_pkg::EigW-1:0]      eig_small;
	logic                                 last_out;

	modport source (output valid, eig_large, eig_small, last_out, input ready);
	modport sink   (input valid, eig_large, eig_small, last_out, output ready);
endinterface

>>> src/symmetric_2x2_eigenvalues_unit.sv
// Throughput: one matrix per cycle while the result side keeps ready high.
// Depth is set by the 33-stage bit-per-stage square root behind 4 front stages.
// The whole pipe advances together; it stalls only while a result waits untaken.
// Reset (arst_n low, asynchronous) clears all valid bits; the pipe starts empty.
// ----------------------------------------------------------------------------
// symmetric_2x2_eigenvalues_unit
// Eigenvalues of [[xx, xy], [xy, yy]] as (xx+yy +/- floor(sqrt(disc)))/2.
// ----------------------------------------------------------------------------
module symmetric_2x2_eigenvalues_unit (
	input  logic        clk,
	input  logic        arst_n,
	s2e_in_if.sink      matrix,
	s2e_out_if.source   eigen
);

	logic                               en;
	logic                               front_vld, sqrt_vld;
	s2e_pkg::front_t                    front;
	s2e_pkg::sqrt_t                     sq;
	logic                               vld_s38;
	logic signed [s2e_pkg::EigW-1:0]    large_s38, small_s38;
	logic                               last_s38;
	logic signed [s2e_pkg::EigW:0]      sum_ext, root_ext, hi_sum, lo_sum;

	// advance whenever the output slot is free or being taken
	assign en           = !vld_s38 || eigen.ready;
	assign matrix.ready = en;

	s2e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld      (matrix.valid),
		.entry_xx (matrix.entry_xx),
		.entry_xy (matrix.entry_xy),
		.entry_yy (matrix.entry_yy),
		.last_in  (matrix.last_in),
		.vld_out  (front_vld),
		.front    (front)
	);

	s2e_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (front_vld),
		.front   (front),
		.vld_out (sqrt_vld),
		.res     (sq)
	);

	// combine trace and root, halve with floor
	assign sum_ext  = {{2{sq.sum[s2e_pkg::SumW-1]}}, sq.sum};
	assign root_ext = {2'b00, sq.root};
	assign hi_sum   = sum_ext + root_ext;
	assign lo_sum   = sum_ext - root_ext;

	// hold output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s38 <= 1'b0;
		end else if (en) begin
			vld_s38 <= sqrt_vld;
		end
	end

	// hold output payload
	always_ff @(posedge clk) begin
		if (en) begin
			large_s38 <= hi_sum[s2e_pkg::EigW:1];
			small_s38 <= lo_sum[s2e_pkg::EigW:1];
			last_s38  <= sq.last;
		end
	end

	assign eigen.valid     = vld_s38;
	assign eigen.eig_large = large_s38;
	assign eigen.eig_small = small_s38;
	assign eigen.last_out  = last_s38;

endmodule

>>> src/s2e_front.sv
// ----------------------------------------------------------------------------
// s2e_front
// Four stages: trace and difference, magnitudes, squares, discriminant sum.
// ----------------------------------------------------------------------------
module s2e_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 vld,
	input  logic signed [s2e_pkg::EntryW-1:0]    entry_xx,
	input  logic signed [s2e_pkg::EntryW-1:0]    entry_xy,
	input  logic signed [s2e_pkg::EntryW-1:0]    entry_yy,
	input  logic                                 last_in,
	output logic                                 vld_out,
	output s2e_pkg::front_t                      front
);

	logic                                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [s2e_pkg::SumW-1:0]      diff_s1, sum_s1, sum_s2, sum_s3, sum_s4;
	logic signed [s2e_pkg::EntryW-1:0]    xy_s1;
	logic                                 last_s1, last_s2, last_s3, last_s4;
	logic [s2e_pkg::EntryW-1:0]           ad_s2, ac_s2;
	logic [s2e_pkg::ProdW-1:0]            dsq_s3;
	logic [s2e_pkg::ProdW-2:0]            csq_s3;
	logic [s2e_pkg::RadW-1:0]             rad_s4;

	logic signed [s2e_pkg::SumW-1:0]      xx_ext, yy_ext;
	logic [s2e_pkg::SumW-1:0]             diff_neg;
	logic [s2e_pkg::ProdW-1:0]            dsq, csq;

	// widen entries by sign
	assign xx_ext   = {entry_xx[s2e_pkg::EntryW-1], entry_xx};
	assign yy_ext   = {entry_yy[s2e_pkg::EntryW-1], entry_yy};
	assign diff_neg = -diff_s1;
	assign dsq      = ad_s2 * ad_s2;
	assign csq      = ac_s2 * ac_s2;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			// trace and difference
			diff_s1 <= xx_ext - yy_ext;
			sum_s1  <= xx_ext + yy_ext;
			xy_s1   <= entry_xy;
			last_s1 <= last_in;
			// magnitudes; |xx-yy| stays below 2^32
			ad_s2   <= diff_s1[s2e_pkg::SumW-1] ? diff_neg[s2e_pkg::EntryW-1:0]
				: diff_s1[s2e_pkg::EntryW-1:0];
			ac_s2   <= xy_s1[s2e_pkg::EntryW-1]
				? (~xy_s1 + s2e_pkg::EntryW'(1)) : xy_s1;
			sum_s2  <= sum_s1;
			last_s2 <= last_s1;
			// squares
			dsq_s3  <= dsq;
			csq_s3  <= csq[s2e_pkg::ProdW-2:0];
			sum_s3  <= sum_s2;
			last_s3 <= last_s2;
			// discriminant
			rad_s4  <= {2'b00, dsq_s3} + {1'b0, csq_s3, 2'b00};
			sum_s4  <= sum_s3;
			last_s4 <= last_s3;
		end
	end

	assign vld_out    = vld_s4;
	assign front.rad  = rad_s4;
	assign front.sum  = sum_s4;
	assign front.last = last_s4;

endmodule

>>> src/s2e_sqrt.sv
// ----------------------------------------------------------------------------
// s2e_sqrt
// Restoring integer square root, one result bit per stage, MSB first.
// ----------------------------------------------------------------------------
module s2e_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld,
	input  s2e_pkg::front_t     front,
	output logic                vld_out,
	output s2e_pkg::sqrt_t      res
);

	logic           vld_s [s2e_pkg::SqrtStages];
	s2e_pkg::sqrt_t pipe_s[s2e_pkg::SqrtStages];
	s2e_pkg::sqrt_t head;

	// seed: whole discriminant as remainder, empty root
	always_comb begin
		head.rem  = {1'b0, front.rad};
		head.root = '0;
		head.sum  = front.sum;
		head.last = front.last;
	end

	for (genvar k = 0; k < s2e_pkg::SqrtStages; k++) begin : g_stage
		localparam int Bit = s2e_pkg::RootW - 1 - k;

		s2e_pkg::sqrt_t          prev;
		s2e_pkg::sqrt_t          nxt;
		logic                    prev_vld;
		logic [s2e_pkg::RemW-1:0] trial;

		if (k == 0) begin : g_first
			assign prev     = head;
			assign prev_vld = vld;
		end else begin : g_rest
			assign prev     = pipe_s[k-1];
			assign prev_vld = vld_s[k-1];
		end

		// try setting this bit: subtract 2*root*2^b + 2^(2b)
		always_comb begin
			trial = (s2e_pkg::RemW'(prev.root) << (Bit + 1))
				| (s2e_pkg::RemW'(1) << (2 * Bit));
			nxt = prev;
			if (prev.rem >= trial) begin
				nxt.rem       = prev.rem - trial;
				nxt.root[Bit] = 1'b1;
			end
		end

		// hold stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= prev_vld;
			end
		end

		// hold stage payload
		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s[k] <= nxt;
			end
		end
	end

	assign vld_out = vld_s[s2e_pkg::SqrtStages-1];
	assign res     = pipe_s[s2e_pkg::SqrtStages-1];

endmodule
